// ----- hdl/csrm_pkg.sv -----
package csrm_pkg;

   // field widths of one input word
   localparam int VENDOR_W   = 32;
   localparam int SIG_W      = 32;
   localparam int FAMILY_W   = 9;
   localparam int MODEL_W    = 8;
   localparam int STEPPING_W = 4;
   localparam int INDEX_W    = 4;

   // req_tdata: vendor_low, vendor_mid, vendor_high, signature, bounds; padded to bytes
   localparam int REQ_DATA_USED = 3 * VENDOR_W + SIG_W + 2 * FAMILY_W + 2 * MODEL_W
                                  + 2 * STEPPING_W;
   localparam int REQ_DATA_W    = ((REQ_DATA_USED + 7) / 8) * 8;

   // rsp_tdata: rule_index, family_out, model_out, stepping_out; padded to bytes
   localparam int RSP_DATA_USED = INDEX_W + FAMILY_W + MODEL_W + STEPPING_W;
   localparam int RSP_DATA_W    = ((RSP_DATA_USED + 7) / 8) * 8;

   typedef enum logic {
      OP_ADD      = 1'b0,
      OP_CLASSIFY = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_MATCH    = 2'd0,
      ST_NO_MATCH = 2'd1,
      ST_ADDED    = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   // one table row, bounds above the vendor words
   typedef struct packed {
      logic [STEPPING_W-1:0] stp_hi;
      logic [STEPPING_W-1:0] stp_lo;
      logic [MODEL_W-1:0]    mdl_hi;
      logic [MODEL_W-1:0]    mdl_lo;
      logic [FAMILY_W-1:0]   fam_hi;
      logic [FAMILY_W-1:0]   fam_lo;
      logic [VENDOR_W-1:0]   vendor_high;
      logic [VENDOR_W-1:0]   vendor_mid;
      logic [VENDOR_W-1:0]   vendor_low;
   } rule_type;

   localparam int RULE_W = $bits(rule_type);

endpackage

// ----- hdl/cpu_signature_rule_matcher.sv -----
// First-match range rule table for processor signatures.
//
// Input channel (req_*): one word per request. req_tuser selects the
// operation: add a rule, or classify a signature. An add stores the vendor
// words and the family/model/stepping bounds in the next free row, or
// answers "table full" once MAX_RULES rows are in use. A classify decodes
// the signature (family = base + extended, model = extended:base) and
// returns the first row, in insertion order, whose vendor equals and whose
// three ranges all hold the decoded values.
// Result channel (rsp_*): exactly one word per request, in request order.
// Sequence: an accepted add moves to the done step and then loads the output
// register that drives rsp_tvalid. A classify walks the rule memory one row per
// cycle through its registered read port, and stops early when a row matches.
// Throughput: one request at a time; req_tready rises again once the result
// sits in the output register, so the next request is taken while that
// result still waits for rsp_tready.
// Reset: clears the rule count and drops any pending result; the rule
// memory itself is not cleared, rows are read only after being written.
// Receiver stall: the result holds in the output register; the finished
// request waits in its final step until the register frees up.
module cpu_signature_rule_matcher #(
   parameter int MAX_RULES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // low to high: vendor_low, vendor_mid, vendor_high, signature, family low
   // bound, family high bound, model low bound, model high bound, stepping
   // low bound, stepping high bound, zero pad
   input  logic [csrm_pkg::REQ_DATA_W-1:0]   req_tdata,
   // operation
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // low to high: rule_index, family_out, model_out, stepping_out, zero pad
   output logic [csrm_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // status
   output logic [1:0]                        rsp_tuser
);

   import csrm_pkg::*;

   localparam int IW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
   localparam int CW = $clog2(MAX_RULES + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   // unpack the request word
   logic [VENDOR_W-1:0]   req_vendor_low;
   logic [VENDOR_W-1:0]   req_vendor_mid;
   logic [VENDOR_W-1:0]   req_vendor_high;
   logic [SIG_W-1:0]      req_signature;
   rule_type              req_rule;

   assign req_vendor_low  = req_tdata[VENDOR_W-1:0];
   assign req_vendor_mid  = req_tdata[2*VENDOR_W-1:VENDOR_W];
   assign req_vendor_high = req_tdata[3*VENDOR_W-1:2*VENDOR_W];
   assign req_signature   = req_tdata[3*VENDOR_W+SIG_W-1:3*VENDOR_W];
   // the bounds follow in the same order as the row layout
   assign req_rule = rule_type'({req_tdata[REQ_DATA_USED-1:3*VENDOR_W+SIG_W],
                                 req_vendor_high, req_vendor_mid, req_vendor_low});

   // state
   state_type             state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         issue_ff, issue_in;
   logic                  pend_ff, pend_in;
   logic [IW-1:0]         pend_idx_ff, pend_idx_in;

   // classify key and decoded signature
   logic [VENDOR_W-1:0]   key_low_ff, key_low_in;
   logic [VENDOR_W-1:0]   key_mid_ff, key_mid_in;
   logic [VENDOR_W-1:0]   key_high_ff, key_high_in;
   logic [FAMILY_W-1:0]   fam_ff, fam_in;
   logic [MODEL_W-1:0]    mod_ff, mod_in;
   logic [STEPPING_W-1:0] step_ff, step_in;

   // finished result waiting for the output register
   status_type            res_status_ff, res_status_in;
   logic [INDEX_W-1:0]    res_index_ff, res_index_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   status_type            rsp_status_ff, rsp_status_in;

   // rule memory ports
   logic                  ram_wr_en;
   logic [IW-1:0]         ram_wr_addr;
   logic                  ram_rd_en;
   logic [IW-1:0]         ram_rd_addr;
   logic [RULE_W-1:0]     ram_rd_data;
   rule_type              row;
   logic                  hit;
   logic                  accept;
   logic                  last_row;

   csrm_ram #(
      .WIDTH (RULE_W),
      .DEPTH (MAX_RULES),
      .AW    (IW)
   ) u_rules (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_rule),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   // compare the row that came back from the memory against the key
   assign row = rule_type'(ram_rd_data);
   assign hit = (row.vendor_low == key_low_ff) && (row.vendor_mid == key_mid_ff) &&
                (row.vendor_high == key_high_ff) &&
                (fam_ff >= row.fam_lo) && (fam_ff <= row.fam_hi) &&
                (mod_ff >= row.mdl_lo) && (mod_ff <= row.mdl_hi) &&
                (step_ff >= row.stp_lo) && (step_ff <= row.stp_hi);
   assign last_row = (CW'(pend_idx_ff) + CW'(1)) == count_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      key_low_in    = key_low_ff;
      key_mid_in    = key_mid_ff;
      key_high_in   = key_high_ff;
      fam_in        = fam_ff;
      mod_in        = mod_ff;
      step_in       = step_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = count_ff[IW-1:0];
      ram_rd_en     = 1'b0;
      ram_rd_addr   = issue_ff[IW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               key_low_in  = req_vendor_low;
               key_mid_in  = req_vendor_mid;
               key_high_in = req_vendor_high;
               issue_in    = '0;
               state_in    = S_DONE;
               if (op_type'(req_tuser) == OP_ADD) begin
                  fam_in  = '0;
                  mod_in  = '0;
                  step_in = '0;
                  if (count_ff == CW'(MAX_RULES)) begin
                     res_status_in = ST_FULL;
                     res_index_in  = '0;
                  end else begin
                     // append at the next free row
                     ram_wr_en     = 1'b1;
                     res_status_in = ST_ADDED;
                     res_index_in  = INDEX_W'(count_ff);
                     count_in      = count_ff + CW'(1);
                  end
               end else begin
                  fam_in  = FAMILY_W'(req_signature[11:8]) +
                            FAMILY_W'(req_signature[27:20]);
                  mod_in  = {req_signature[19:16], req_signature[7:4]};
                  step_in = req_signature[3:0];
                  res_status_in = ST_NO_MATCH;
                  res_index_in  = '0;
                  if (count_ff != '0) begin
                     state_in = S_SCAN;
                  end
               end
            end
         end
         S_SCAN: begin
            if (pend_ff && hit) begin
               res_status_in = ST_MATCH;
               res_index_in  = INDEX_W'(pend_idx_ff);
               state_in      = S_DONE;
            end else if (pend_ff && last_row) begin
               res_status_in = ST_NO_MATCH;
               res_index_in  = '0;
               state_in      = S_DONE;
            end else if (issue_ff < count_ff) begin
               // advance the read pointer one row per cycle
               ram_rd_en   = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = issue_ff[IW-1:0];
               issue_in    = issue_ff + CW'(1);
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_data_in   = RSP_DATA_W'({step_ff, mod_ff, fam_ff, res_index_ff});
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         issue_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_idx_ff   <= pend_idx_in;
      key_low_ff    <= key_low_in;
      key_mid_ff    <= key_mid_in;
      key_high_ff   <= key_high_in;
      fam_ff        <= fam_in;
      mod_ff        <= mod_in;
      step_ff       <= step_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   // the table never holds more rows than it has
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_RULES))
      else $error("rule count beyond table size");

   // an accepted request always leaves the idle step
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("request accepted but block stayed idle");

   // a successful add grows the table by exactly one row
   a_add_count: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_tuser == OP_ADD) && (count_ff != CW'(MAX_RULES)))
      |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("add did not advance rule count");

   // a memory read is outstanding only during a scan
   a_pend_scan: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == S_SCAN))
      else $error("row read outstanding outside scan");

endmodule

// ----- hdl/csrm_ram.sv -----
module csrm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- tb/cpu_signature_rule_matcher_test.sv -----
`timescale 1ns / 100ps

module cpu_signature_rule_matcher_test;
   import csrm_pkg::*;

   // table depth of the instance; also the depth of the shadow tables below
   localparam int TABLE_DEPTH = 16;
   // highest family that any signature can decode to: 15 + 255
   localparam int FAMILY_REACH = 270;
   // vendor strings shared by rules and lookups so that lookups can hit
   localparam int POOL_SIZE = 6;
   // random words after the directed opening
   localparam int RANDOM_WORDS = 1090;
   // watchdog limit on the whole run, with a wide margin over the slowest word
   localparam int CYCLE_LIMIT = 400000;
   // drain time after the last result: classify walk plus margin
   localparam int DRAIN_CYCLES = 40;

   // one word offered on the request channel
   typedef struct {
      op_type                 op;
      rule_type               rule;
      logic [SIG_W-1:0]       signature;
   } request_type;

   // one word expected on the result channel
   typedef struct {
      status_type             status;
      logic [INDEX_W-1:0]     index;
      logic [FAMILY_W-1:0]    family;
      logic [MODEL_W-1:0]     model;
      logic [STEPPING_W-1:0]  stepping;
   } match_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // low to high: vendor_low, vendor_mid, vendor_high, signature, family low
   // bound, family high bound, model low bound, model high bound, stepping
   // low bound, stepping high bound, zero pad
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // operation
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // low to high: rule_index, family_out, model_out, stepping_out, zero pad
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // status
   logic [1:0]            rsp_tuser;

   // words waiting for the driver, and the word now on the bus
   request_type      pending_requests[$];
   request_type      in_flight;
   // results owed by the block, oldest first
   match_result_type owed_results[$];

   // rule table as the predictor sees it (updated at acceptance)
   rule_type         table_rules[TABLE_DEPTH];
   int               table_count = 0;

   // rule table as the stimulus generator sees it (updated at queueing)
   rule_type         queued_rules[TABLE_DEPTH];
   int               queued_count = 0;
   logic [95:0]      vendor_pool[POOL_SIZE];

   int               gap_left = 0;
   int               stall_left = 0;
   int               words_issued = 0;
   int               words_taken = 0;
   int               words_accepted = 0;
   int               failures = 0;
   int               cycle_count = 0;

   cpu_signature_rule_matcher #(
      .MAX_RULES (TABLE_DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin : clock_gen
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Idle cycles before a word (driver) or before taking a result (monitor).
   // Every fourth stretch of 48 words runs back to back.
   function automatic int wait_cycles(input int n);
      if ((n / 48) % 4 == 3) return 0;
      return $urandom_range(0, 11);
   endfunction

   // Pack a request word, first field in the lowest bits, zero pad on top.
   function automatic logic [REQ_DATA_W-1:0] pack_request(input request_type rq);
      logic [REQ_DATA_W-1:0] word;
      word = '0;
      word[REQ_DATA_USED-1:0] = {rq.rule.stp_hi, rq.rule.stp_lo,
                                 rq.rule.mdl_hi, rq.rule.mdl_lo,
                                 rq.rule.fam_hi, rq.rule.fam_lo,
                                 rq.signature, rq.rule.vendor_high,
                                 rq.rule.vendor_mid, rq.rule.vendor_low};
      return word;
   endfunction

   // Work out the result of one accepted word and advance the shadow table.
   task automatic predict_result(input request_type rq);
      match_result_type res;
      rule_type         r;
      int               fam;
      logic [MODEL_W-1:0]    mdl;
      logic [STEPPING_W-1:0] stp;
      bit               found;
      res.index    = '0;
      res.family   = '0;
      res.model    = '0;
      res.stepping = '0;
      if (rq.op == OP_ADD) begin
         if (table_count >= TABLE_DEPTH) begin
            res.status = ST_FULL;
         end else begin
            table_rules[table_count] = rq.rule;
            res.index  = table_count[INDEX_W-1:0];
            res.status = ST_ADDED;
            table_count++;
         end
      end else begin
         // family is base plus extended, model is extended joined with base
         fam = int'(rq.signature[11:8]) + int'(rq.signature[27:20]);
         mdl = {rq.signature[19:16], rq.signature[7:4]};
         stp = rq.signature[3:0];
         res.family   = fam[FAMILY_W-1:0];
         res.model    = mdl;
         res.stepping = stp;
         res.status   = ST_NO_MATCH;
         found = 1'b0;
         // first hit in insertion order wins; empty ranges never hit
         for (int i = 0; i < table_count; i++) begin
            r = table_rules[i];
            if (!found && r.vendor_low == rq.rule.vendor_low &&
                r.vendor_mid == rq.rule.vendor_mid &&
                r.vendor_high == rq.rule.vendor_high &&
                fam >= int'(r.fam_lo) && fam <= int'(r.fam_hi) &&
                mdl >= r.mdl_lo && mdl <= r.mdl_hi &&
                stp >= r.stp_lo && stp <= r.stp_hi) begin
               found      = 1'b1;
               res.status = ST_MATCH;
               res.index  = i[INDEX_W-1:0];
            end
         end
      end
      owed_results.insert(owed_results.size(), res);
   endtask

   function automatic void report_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
         failures++;
      end
   endfunction

   // Compare the result word on the bus with the oldest owed result.
   task automatic check_result();
      match_result_type exp_r;
      if (owed_results.size() == 0) begin
         $display("%0t: result word with nothing owed, expected none, actual status %0d",
                  $time, rsp_tuser);
         failures++;
      end else begin
         exp_r = owed_results.pop_front();
         if ($isunknown({rsp_tuser, rsp_tdata})) begin
            $display("%0t: unknown bits in result, expected %0d, actual %h", $time,
                     exp_r.status, {rsp_tuser, rsp_tdata});
            failures++;
         end
         report_field("status", int'(exp_r.status), int'(rsp_tuser));
         report_field("rule_index", int'(exp_r.index), int'(rsp_tdata[3:0]));
         report_field("family_out", int'(exp_r.family), int'(rsp_tdata[12:4]));
         report_field("model_out", int'(exp_r.model), int'(rsp_tdata[20:13]));
         report_field("stepping_out", int'(exp_r.stepping), int'(rsp_tdata[24:21]));
      end
   endtask

   // Queue an add; the generator shadow follows so lookups can aim at rules.
   task automatic push_add(input logic [95:0] vendor, input int fmin, input int fmax,
                           input int mmin, input int mmax, input int smin, input int smax);
      request_type rq;
      rq.op                = OP_ADD;
      rq.signature         = $urandom;
      rq.rule.vendor_low   = vendor[31:0];
      rq.rule.vendor_mid   = vendor[63:32];
      rq.rule.vendor_high  = vendor[95:64];
      rq.rule.fam_lo       = fmin[FAMILY_W-1:0];
      rq.rule.fam_hi       = fmax[FAMILY_W-1:0];
      rq.rule.mdl_lo       = mmin[MODEL_W-1:0];
      rq.rule.mdl_hi       = mmax[MODEL_W-1:0];
      rq.rule.stp_lo       = smin[STEPPING_W-1:0];
      rq.rule.stp_hi       = smax[STEPPING_W-1:0];
      pending_requests.insert(pending_requests.size(), rq);
      if (queued_count < TABLE_DEPTH) begin
         queued_rules[queued_count] = rq.rule;
         queued_count++;
      end
   endtask

   // Queue a classify; the bound fields carry noise the block must ignore.
   task automatic push_classify(input logic [95:0] vendor, input logic [31:0] sig);
      request_type rq;
      rq.op                = OP_CLASSIFY;
      rq.signature         = sig;
      rq.rule.vendor_low   = vendor[31:0];
      rq.rule.vendor_mid   = vendor[63:32];
      rq.rule.vendor_high  = vendor[95:64];
      rq.rule.fam_lo       = FAMILY_W'($urandom);
      rq.rule.fam_hi       = FAMILY_W'($urandom);
      rq.rule.mdl_lo       = MODEL_W'($urandom);
      rq.rule.mdl_hi       = MODEL_W'($urandom);
      rq.rule.stp_lo       = STEPPING_W'($urandom);
      rq.rule.stp_hi       = STEPPING_W'($urandom);
      pending_requests.insert(pending_requests.size(), rq);
   endtask

   // Draw rule bounds: full, narrow, random, empty, single value, or up to the top.
   task automatic pick_range(input int top, input int reach, output int lo, output int hi);
      case ($urandom_range(0, 5))
         0: begin
            lo = 0;
            hi = top;
         end
         1: begin
            lo = $urandom_range(0, reach);
            hi = lo + $urandom_range(0, 3);
            if (hi > top) hi = top;
         end
         2: begin
            lo = $urandom_range(0, reach);
            hi = $urandom_range(0, top);
         end
         3: begin
            hi = $urandom_range(0, top - 1);
            lo = $urandom_range(hi + 1, top);
         end
         4: begin
            lo = $urandom_range(0, reach);
            hi = lo;
         end
         default: begin
            lo = $urandom_range(0, reach);
            hi = top;
         end
      endcase
   endtask

   // Pick a value on, just outside or inside a range, held to the field range.
   function automatic int pick_near(input int lo, input int hi, input int top);
      int v;
      if (lo > hi) return $urandom_range(0, top);
      case ($urandom_range(0, 4))
         0: v = lo;
         1: v = hi;
         2: v = lo - 1;
         3: v = hi + 1;
         default: v = $urandom_range(lo, hi > top ? top : hi);
      endcase
      if (v < 0) v = 0;
      if (v > top) v = top;
      return v;
   endfunction

   // Build a signature that decodes to the given values; split family at random.
   function automatic logic [31:0] make_signature(input int fam, input int mdl, input int stp);
      int          lo_b;
      int          hi_b;
      int          base;
      logic [31:0] s;
      lo_b = fam > 255 ? fam - 255 : 0;
      hi_b = fam < 15 ? fam : 15;
      base = $urandom_range(lo_b, hi_b);
      s = $urandom;
      s[27:20] = 8'(fam - base);
      s[11:8]  = base[3:0];
      s[19:16] = mdl[7:4];
      s[7:4]   = mdl[3:0];
      s[3:0]   = stp[3:0];
      return s;
   endfunction

   // Request driver: hold the word until taken, then idle the drawn gap.
   always @(posedge clock) begin : req_driver
      request_type rq;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left   <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_result(in_flight);
            words_accepted <= words_accepted + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               req_tvalid <= 1'b0;
               gap_left   <= gap_left - 1;
            end else if (pending_requests.size() != 0) begin
               rq = pending_requests.pop_front();
               in_flight  <= rq;
               req_tdata  <= pack_request(rq);
               req_tuser  <= rq.op;
               req_tvalid <= 1'b1;
               gap_left   <= wait_cycles(words_issued);
               words_issued++;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: check each taken word, then drop ready for the drawn stall.
   always @(posedge clock) begin : rsp_monitor
      int s;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         check_result();
         s = wait_cycles(words_taken);
         words_taken++;
         if (s == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            stall_left <= s;
         end
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         if (stall_left == 1) rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      logic [95:0] ones_vendor;
      logic [95:0] vendor;
      rule_type    r;
      int          fl, fh, ml, mh, sl, sh;
      ones_vendor = '1;
      for (int k = 0; k < POOL_SIZE; k++) vendor_pool[k] = {$urandom, $urandom, $urandom};

      // Directed opening.
      // lookup on an empty table, highest decodable family
      push_classify('0, 32'hffff_ffff);
      // rule 0 covers every value; rule 1 has an empty family range
      push_add(vendor_pool[0], 0, 511, 0, 255, 0, 15);
      push_add(vendor_pool[1], 5, 4, 0, 255, 0, 15);
      push_add(vendor_pool[1], 6, 6, 8'h5e, 8'h5e, 3, 3);
      // skip the empty-range rule and hit the single-point rule, then miss by one
      push_classify(vendor_pool[1], 32'h0005_06e3);
      push_classify(vendor_pool[1], 32'h0005_07e3);
      push_classify(vendor_pool[0], 32'h0000_0000);
      push_classify(vendor_pool[0], 32'hffff_ffff);
      // bounds at field maxima: family 511 is out of reach of any signature
      push_add(ones_vendor, 511, 511, 255, 255, 15, 15);
      push_classify(ones_vendor, 32'hffff_ffff);
      // all-zero vendor and bounds
      push_add('0, 0, 0, 0, 0, 0, 0);
      push_classify('0, 32'h0000_0000);
      push_classify('0, 32'h0000_0001);
      // family 270 reached only by base 15 plus extended 255
      push_add(ones_vendor, 270, 511, 255, 255, 15, 15);
      push_classify(ones_vendor, 32'hffff_ffff);
      push_classify(vendor_pool[2], $urandom);

      // Random part: fill the table, keep knocking on it once full,
      // and mostly aim lookups at stored rules near their bounds.
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if ($urandom_range(0, queued_count < TABLE_DEPTH ? 4 : 11) == 0) begin
            if ($urandom_range(0, 9) == 0) vendor = {$urandom, $urandom, $urandom};
            else vendor = vendor_pool[$urandom_range(1, POOL_SIZE - 1)];
            pick_range(511, FAMILY_REACH + 10, fl, fh);
            pick_range(255, 255, ml, mh);
            pick_range(15, 15, sl, sh);
            push_add(vendor, fl, fh, ml, mh, sl, sh);
         end else if ($urandom_range(0, 9) < 7) begin
            r = queued_rules[$urandom_range(0, queued_count - 1)];
            vendor = {r.vendor_high, r.vendor_mid, r.vendor_low};
            // now and then flip one vendor bit to probe the string compare
            if ($urandom_range(0, 7) == 0) vendor[$urandom_range(0, 95)] ^= 1'b1;
            push_classify(vendor, make_signature(
               pick_near(int'(r.fam_lo), int'(r.fam_hi), FAMILY_REACH),
               pick_near(int'(r.mdl_lo), int'(r.mdl_hi), 255),
               pick_near(int'(r.stp_lo), int'(r.stp_hi), 15)));
         end else begin
            if ($urandom_range(0, 1) == 0) vendor = {$urandom, $urandom, $urandom};
            else vendor = vendor_pool[$urandom_range(0, POOL_SIZE - 1)];
            push_classify(vendor, $urandom);
         end
      end

      // release reset once all stimulus is queued
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // drain: every word taken and every owed result seen
      while (pending_requests.size() != 0 || req_tvalid || owed_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && owed_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
